>>> hdl/bpm_pkg.sv
// Package for the button panel mode controller: payload structs, counter widths,
// register indexes and button phase codes. Used by bpm_button and the top level.
`timescale 1ns / 1ps
`default_nettype none

package bpm_pkg;

    localparam int COUNT_WIDTH = 16;
    localparam int CODE_STEPS  = 8;
    localparam int TIMER_WIDTH = 20;
    localparam int CFG_WIDTH   = 16;
    localparam int CMP_WIDTH   = (COUNT_WIDTH > CFG_WIDTH) ? COUNT_WIDTH : CFG_WIDTH;
    localparam int CODE_WIDTH  = 3;
    localparam int STEP_WIDTH  = 5;

    localparam logic [CMP_WIDTH-1:0] DEBOUNCE_RESET = CMP_WIDTH'(50);
    localparam logic [CFG_WIDTH-1:0] HOLD_RESET     = CFG_WIDTH'(100);
    localparam logic [TIMER_WIDTH-1:0] REVERT_RESET = TIMER_WIDTH'(10000);

    localparam int IDX_WIDTH = 3;
    localparam logic [IDX_WIDTH-1:0] REG_DEBOUNCE  = 3'd0;
    localparam logic [IDX_WIDTH-1:0] REG_UP_HOLD   = 3'd1;
    localparam logic [IDX_WIDTH-1:0] REG_DOWN_HOLD = 3'd2;
    localparam logic [IDX_WIDTH-1:0] REG_MODE_HOLD = 3'd3;
    localparam logic [IDX_WIDTH-1:0] REG_REVERT    = 3'd4;

    localparam logic [1:0] PHASE_IDLE         = 2'd0;
    localparam logic [1:0] PHASE_WAIT_RELEASE = 2'd3;

    typedef logic [COUNT_WIDTH-1:0] t_count;
    typedef logic [CFG_WIDTH-1:0]   t_cfg;
    typedef logic [TIMER_WIDTH-1:0] t_timer;
    typedef logic [CODE_WIDTH-1:0]  t_code;

    typedef struct packed {
        logic       raw_up;
        logic       raw_down;
        logic       raw_mode;
        logic [5:0] stored_setting;
    } t_in;

    typedef struct packed {
        logic [2:0] up_code;
        logic [2:0] down_code;
        logic       local_mode;
        logic       codes_updated;
    } t_out;

    // Saturating increment of a debounce or hold counter.
    function automatic t_count sat_inc(input t_count v);
        sat_inc = (v == {COUNT_WIDTH{1'b1}}) ? v : v + t_count'(1);
    endfunction

    // Counter above a 16-bit threshold, compared at the wider of the two widths.
    function automatic logic above(input t_count v, input t_cfg thr);
        above = CMP_WIDTH'(v) > CMP_WIDTH'(thr);
    endfunction

endpackage

`default_nettype wire

>>> hdl/button_panel_mode_controller.sv
// Top level of the button panel mode controller: config registers, mode and code
// state, idle revert timer and a two-entry output stage. Uses bpm_pkg and bpm_button.
`timescale 1ns / 1ps
`default_nettype none

// Each input transaction is one millisecond tick carrying the raw up, down and mode
// levels (1 open) and the stored setting word; each produces exactly one result with
// the two 3-bit codes, the local/remote flag and a codes-updated flag. A tick is
// processed by combinational logic feeding the result register, so one transaction
// is accepted per clock while the skid entry is empty; the two-entry output stage lets
// one more transaction in after the output stalls. Configuration writes must be made
// while the block is idle; unknown register indexes are ignored.
module button_panel_mode_controller (
    input  wire                                  i_clk,
    input  wire                                  i_rst_n,
    input  wire                                  i_in_valid,
    output logic                                 o_in_ready,
    input  wire  bpm_pkg::t_in                   i_in_data,
    output logic                                 o_out_valid,
    input  wire                                  i_out_ready,
    output bpm_pkg::t_out                        o_out_data,
    input  wire                                  i_cfg_valid,
    output logic                                 o_cfg_ready,
    input  wire  [bpm_pkg::IDX_WIDTH-1:0]        i_cfg_index,
    input  wire  [bpm_pkg::TIMER_WIDTH-1:0]      i_cfg_data
);

    bpm_pkg::t_cfg    r_debounce, r_up_hold, r_down_hold, r_mode_hold;
    bpm_pkg::t_timer  r_revert;

    bpm_pkg::t_timer  r_timer, n_timer;
    logic             r_arm, n_arm;
    logic             r_local, n_local;
    bpm_pkg::t_code   r_up, n_up;
    bpm_pkg::t_code   r_down, n_down;
    logic             n_updated;

    bpm_pkg::t_out    r_out, r_skid, result;
    logic             r_out_valid, r_skid_valid;

    logic             accept;
    logic             fire_up, fire_down, fire_mode;
    bpm_pkg::t_code   stored_up, stored_down;

    function automatic bpm_pkg::t_code advance(input bpm_pkg::t_code v);
        logic [bpm_pkg::STEP_WIDTH-1:0] s;
        s = bpm_pkg::STEP_WIDTH'(v) + bpm_pkg::STEP_WIDTH'(1);
        if (s >= bpm_pkg::STEP_WIDTH'(bpm_pkg::CODE_STEPS)) begin
            s = '0;
        end
        advance = s[bpm_pkg::CODE_WIDTH-1:0];
    endfunction

    assign o_in_ready  = !r_skid_valid;
    assign o_cfg_ready = 1'b1;
    assign accept      = i_in_valid && o_in_ready;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;
    assign stored_up   = i_in_data.stored_setting[5:3];
    assign stored_down = i_in_data.stored_setting[2:0];

    bpm_button u_up (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_tick     (accept),
        .i_raw      (i_in_data.raw_up),
        .i_debounce (r_debounce),
        .i_hold     (r_up_hold),
        .o_fire     (fire_up)
    );

    bpm_button u_down (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_tick     (accept),
        .i_raw      (i_in_data.raw_down),
        .i_debounce (r_debounce),
        .i_hold     (r_down_hold),
        .o_fire     (fire_down)
    );

    bpm_button u_mode (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_tick     (accept),
        .i_raw      (i_in_data.raw_mode),
        .i_debounce (r_debounce),
        .i_hold     (r_mode_hold),
        .o_fire     (fire_mode)
    );

    always_comb begin
        n_arm     = 1'b0;
        n_timer   = r_arm ? '0 :
                    ((r_timer == {bpm_pkg::TIMER_WIDTH{1'b1}}) ? r_timer
                                                               : r_timer + bpm_pkg::t_timer'(1));
        n_local   = r_local;
        n_up      = r_up;
        n_down    = r_down;
        n_updated = 1'b0;

        if (n_timer > r_revert && r_local) begin
            n_local   = 1'b0;
            n_up      = stored_up;
            n_down    = stored_down;
            n_updated = 1'b1;
        end

        // Fires in remote mode still restart the idle timer.
        if (fire_up) begin
            n_arm = 1'b1;
            if (n_local) begin
                n_up      = advance(n_up);
                n_updated = 1'b1;
            end
        end
        if (fire_down) begin
            n_arm = 1'b1;
            if (n_local) begin
                n_down    = advance(n_down);
                n_updated = 1'b1;
            end
        end
        if (fire_mode) begin
            n_arm = 1'b1;
            if (n_local) begin
                n_local   = 1'b0;
                n_up      = stored_up;
                n_down    = stored_down;
                n_updated = 1'b1;
            end else begin
                n_local = 1'b1;
            end
        end

        result.up_code       = n_up;
        result.down_code     = n_down;
        result.local_mode    = n_local;
        result.codes_updated = n_updated;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_debounce  <= bpm_pkg::DEBOUNCE_RESET[bpm_pkg::CFG_WIDTH-1:0];
            r_up_hold   <= bpm_pkg::HOLD_RESET;
            r_down_hold <= bpm_pkg::HOLD_RESET;
            r_mode_hold <= bpm_pkg::HOLD_RESET;
            r_revert    <= bpm_pkg::REVERT_RESET;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                bpm_pkg::REG_DEBOUNCE:  r_debounce  <= i_cfg_data[bpm_pkg::CFG_WIDTH-1:0];
                bpm_pkg::REG_UP_HOLD:   r_up_hold   <= i_cfg_data[bpm_pkg::CFG_WIDTH-1:0];
                bpm_pkg::REG_DOWN_HOLD: r_down_hold <= i_cfg_data[bpm_pkg::CFG_WIDTH-1:0];
                bpm_pkg::REG_MODE_HOLD: r_mode_hold <= i_cfg_data[bpm_pkg::CFG_WIDTH-1:0];
                bpm_pkg::REG_REVERT:    r_revert    <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_timer <= '0;
            r_arm   <= 1'b0;
            r_local <= 1'b0;
            r_up    <= '0;
            r_down  <= '0;
        end else if (accept) begin
            r_timer <= n_timer;
            r_arm   <= n_arm;
            r_local <= n_local;
            r_up    <= n_up;
            r_down  <= n_down;
        end
    end

    // Output register with a skid entry behind it; input stalls only when the skid is full.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (!r_out_valid || i_out_ready) begin
            if (r_skid_valid) begin
                r_out        <= r_skid;
                r_out_valid  <= 1'b1;
                r_skid_valid <= 1'b0;
            end else begin
                r_out       <= result;
                r_out_valid <= accept;
            end
        end else if (accept) begin
            r_skid       <= result;
            r_skid_valid <= 1'b1;
        end
    end

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_valid |-> r_out_valid)
        else $error("skid entry held while output register is empty");

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && !i_out_ready |=> r_out_valid)
        else $error("stalled result dropped");

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept && !n_updated |-> (n_up == r_up) && (n_down == r_down))
        else $error("codes changed without codes_updated");

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept && r_arm |=> r_timer == '0)
        else $error("idle timer not restarted after a fire");

endmodule

`default_nettype wire

>>> hdl/bpm_button.sv
// One button of the panel: debounce of the raw level, hold detection and release wait.
// Depends on bpm_pkg for counter types and phase codes.
`timescale 1ns / 1ps
`default_nettype none

module bpm_button (
    input  wire                i_clk,
    input  wire                i_rst_n,
    input  wire                i_tick,
    input  wire                i_raw,
    input  wire bpm_pkg::t_cfg i_debounce,
    input  wire bpm_pkg::t_cfg i_hold,
    output logic               o_fire
);

    logic                 r_last_raw, n_last_raw;
    logic                 r_clean, n_clean;
    bpm_pkg::t_count      r_stable, n_stable;
    logic [1:0]           r_phase, n_phase;
    bpm_pkg::t_count      r_press, n_press;
    bpm_pkg::t_count      r_release, n_release;
    bpm_pkg::t_count      press_inc;
    bpm_pkg::t_count      release_inc;

    always_comb begin
        n_last_raw = i_raw;
        n_stable   = (i_raw != r_last_raw) ? '0 : bpm_pkg::sat_inc(r_stable);
        n_clean    = bpm_pkg::above(n_stable, i_debounce) ? i_raw : r_clean;
        n_phase    = r_phase;
        n_press    = r_press;
        n_release  = r_release;
        o_fire     = 1'b0;
        press_inc  = bpm_pkg::sat_inc(r_press);

        // Any phase code other than wait-release behaves as idle.
        if (r_phase != bpm_pkg::PHASE_WAIT_RELEASE) begin
            if (n_clean) begin
                n_press = '0;
            end else if (bpm_pkg::above(press_inc, i_hold)) begin
                o_fire    = 1'b1;
                n_phase   = bpm_pkg::PHASE_WAIT_RELEASE;
                n_press   = '0;
                n_release = '0;
            end else begin
                n_press = press_inc;
            end
        end

        // The release check sees the phase as left by the press check.
        release_inc = bpm_pkg::sat_inc(n_release);
        if (n_phase == bpm_pkg::PHASE_WAIT_RELEASE) begin
            if (!n_clean) begin
                n_release = '0;
            end else if (bpm_pkg::above(release_inc, i_hold)) begin
                n_phase   = bpm_pkg::PHASE_IDLE;
                n_release = '0;
                n_press   = '0;
            end else begin
                n_release = release_inc;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_last_raw <= 1'b0;
            r_clean    <= 1'b1;
            r_stable   <= '0;
            r_phase    <= bpm_pkg::PHASE_IDLE;
            r_press    <= '0;
            r_release  <= '0;
        end else if (i_tick) begin
            r_last_raw <= n_last_raw;
            r_clean    <= n_clean;
            r_stable   <= n_stable;
            r_phase    <= n_phase;
            r_press    <= n_press;
            r_release  <= n_release;
        end
    end

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_tick && o_fire |=> r_phase == bpm_pkg::PHASE_WAIT_RELEASE)
        else $error("button fired without entering wait-release");

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_phase == bpm_pkg::PHASE_WAIT_RELEASE |-> r_press == '0)
        else $error("press count running during wait-release");

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_clean |-> r_release == '0)
        else $error("release count running while pressed");

endmodule

`default_nettype wire
